[hw/rtl/pmrs_pkg.sv]
// Shared types and constants for the power monitor reading scaler.
package pmrs_pkg;

    // Operation selector carried in s_axis_tuser
    typedef enum logic [1:0] {
        OP_BUS_VOLTAGE = 2'd0,
        OP_CURRENT     = 2'd1,
        OP_POWER       = 2'd2,
        OP_CALIBRATION = 2'd3
    } op_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_SHUNT = 1'b0,
        CFG_CORR  = 1'b1
    } cfg_idx_t;

    // Setup sequencer states
    typedef enum logic [3:0] {
        DER_IDLE,
        DER_START,
        DER_DIV_Q,
        DER_ROUND,
        DER_DIV_K,
        DER_MA,
        DER_LSB,
        DER_DEN,
        DER_DEN_K,
        DER_DIV_CAL
    } der_state_t;

    localparam int RAW_W   = 16;
    localparam int MAG_W   = 17;
    localparam int LSB_W   = 22;
    localparam int PROD_W  = 38;
    localparam int QUO_W   = 32;
    localparam int DIVR_W  = 10;
    localparam int VAL_W   = 33;
    localparam int TDATA_W = 40;

    // Item divider: 4 quotient bits per stage, 8 stages
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = QUO_W / DIV_STEP;

    // Per-item scaling constants
    localparam logic [LSB_W-1:0]  BUS_COEF = 22'd5;     // *125/100 == *5/4
    localparam logic [LSB_W-1:0]  UNIT_COEF = 22'd1;
    localparam logic [DIVR_W-1:0] BUS_DIV  = 10'd4;
    localparam logic [DIVR_W-1:0] CUR_DIV  = 10'd1000;
    localparam logic [DIVR_W-1:0] PWR_DIV  = 10'd40;
    localparam logic [DIVR_W-1:0] CAL_DIV  = 10'd1;

    // Setup serial divider
    localparam int SER_W = 49;
    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] SER_LAST = 6'd48;
    localparam logic [16:0] FULL_SCALE_NUM = 17'd81920;
    localparam logic [9:0]  DEC_THOUSAND   = 10'd1000;
    localparam logic [9:0]  DEC_HUNDRED    = 10'd100;
    localparam logic [9:0]  DEC_TEN        = 10'd10;
    localparam logic [19:0] NA_PER_MA      = 20'd1000000;
    localparam int          LSB_SHIFT      = 15;        // / 32768
    localparam logic [9:0]  DEN_SCALE      = 10'd1000;
    // 5120000000 == 78125 << 16
    localparam logic [16:0] CAL_NUM_K      = 17'd78125;
    localparam int          CAL_NUM_SHIFT  = 16;

    // Sideband that rides along the item divider
    typedef struct packed {
        logic neg;
        logic err;
    } side_t;

    // Derived scaling terms handed from setup to the datapath
    typedef struct packed {
        logic             ready;
        logic             err;
        logic [LSB_W-1:0] lsb;
        logic [15:0]      cal;
    } scale_t;

endpackage

[hw/rtl/power_monitor_reading_scaler.sv]
// Top level of the power monitor reading scaler: register file, item pipeline, output stage.
//
// Usage:
//  s_axis  : one word per reading; s_axis_tdata = raw register word, s_axis_tuser =
//            operation (bus voltage, current, power, calibration word).
//  m_axis  : one word per reading; m_axis_tdata = 33-bit two's complement value
//            (mV, uA, uW or calibration word), m_axis_tuser = scale error flag.
//  cfg     : register writes (index 0 shunt milliohms, index 1 correction factor),
//            always accepted; only issue them with no readings in flight.
// Pipeline: input register, multiplier, 8 divider stages of 4 quotient bits, sign stage.
// Throughput: one word per cycle outside setup; a stage holds when its successor is full,
//  so bubbles close up and input keeps flowing while a result waits on m_axis_tready.
// After reset and after every register write the setup sequencer recomputes the
//  current LSB and calibration word with a one-bit-per-cycle serial divider,
//  ending early with a zero shunt or when the shunt gives no full-scale current;
//  while it runs s_axis_tready is low.
// Reset: pipeline emptied, registers back to shunt 10 and correction 1000.
module power_monitor_reading_scaler (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input words
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,   // [15:0] raw_word
    input  logic [1:0]                    s_axis_tuser,   // [1:0] operation
    // result words
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [pmrs_pkg::TDATA_W-1:0]  m_axis_tdata,   // [32:0] scaled_value, rest zero
    output logic [0:0]                    m_axis_tuser,   // [0] scale_error
    // register writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [0:0]                    cfg_index,
    input  logic [15:0]                   cfg_wdata
);
    import pmrs_pkg::*;

    // ---------------- configuration registers ----------------
    logic        cfg_write;
    logic [15:0] shunt_reg, shunt_next;
    logic [15:0] corr_reg, corr_next;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb begin
        shunt_next = shunt_reg;
        corr_next  = corr_reg;
        if (cfg_write) begin
            case (cfg_idx_t'(cfg_index))
                CFG_SHUNT: shunt_next = cfg_wdata;
                CFG_CORR:  corr_next  = cfg_wdata;
                default:   shunt_next = shunt_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shunt_reg <= 16'd10;
            corr_reg  <= 16'd1000;
        end else begin
            shunt_reg <= shunt_next;
            corr_reg  <= corr_next;
        end
    end

    // setup terms: user keeps them stable with readings in flight; block does not enforce
    scale_t scale;

    pmrs_derive u_derive (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cfg_write),
        .shunt   (shunt_reg),
        .corr    (corr_reg),
        .scale   (scale)
    );

    // ---------------- stage handshake ----------------
    logic a_en, b_en, o_en;
    logic div_in_ready, div_out_valid;
    logic s_accept;

    logic a_valid_reg, b_valid_reg, o_valid_reg;

    assign o_en = !o_valid_reg || m_axis_tready;
    assign b_en = !b_valid_reg || div_in_ready;
    assign a_en = !a_valid_reg || b_en;

    // no intake while setup runs or a register write is on the port
    assign s_axis_tready = a_en && scale.ready && !cfg_valid;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // ---------------- stage A: operand select ----------------
    // Every operation becomes (a * b) / divisor; error forces b to zero.
    op_t               op;
    logic [RAW_W-1:0]  raw;
    logic              a_neg;
    logic [MAG_W-1:0]  a_mag;
    logic [MAG_W-1:0]  a_mul_next, a_mul_reg;
    logic [LSB_W-1:0]  a_coef_next, a_coef_reg;
    logic [DIVR_W-1:0] a_divisor_next, a_divisor_reg;
    side_t             a_side_next, a_side_reg;

    assign op    = op_t'(s_axis_tuser);
    assign raw   = s_axis_tdata;
    // current readings are two's complement: work on the magnitude
    assign a_neg = (op == OP_CURRENT) && raw[RAW_W-1];
    assign a_mag = a_neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};

    always_comb begin
        a_mul_next      = a_mag;
        a_coef_next     = scale.lsb;
        a_divisor_next  = CUR_DIV;
        a_side_next.neg = a_neg;
        a_side_next.err = (op != OP_BUS_VOLTAGE) && scale.err;
        case (op)
            OP_BUS_VOLTAGE: begin
                a_coef_next    = BUS_COEF;
                a_divisor_next = BUS_DIV;
            end
            OP_CURRENT: begin
                a_divisor_next = CUR_DIV;
            end
            OP_POWER: begin
                a_divisor_next = PWR_DIV;
            end
            OP_CALIBRATION: begin
                // word computed at setup; passes through with a unit divisor
                a_mul_next     = {1'b0, scale.cal};
                a_coef_next    = UNIT_COEF;
                a_divisor_next = CAL_DIV;
            end
            default: begin
                a_divisor_next = CUR_DIV;
            end
        endcase
        if (a_side_next.err) begin
            a_coef_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_en) begin
            a_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_en) begin
            a_mul_reg     <= a_mul_next;
            a_coef_reg    <= a_coef_next;
            a_divisor_reg <= a_divisor_next;
            a_side_reg    <= a_side_next;
        end
    end

    // ---------------- stage B: multiply ----------------
    logic [MAG_W+LSB_W-1:0] b_prod_full;
    logic [PROD_W-1:0]      b_prod_reg;
    logic [DIVR_W-1:0]      b_divisor_reg;
    side_t                  b_side_reg;

    // product stays below 2^38 for every reachable operand pair
    assign b_prod_full = (MAG_W+LSB_W)'(a_mul_reg) * (MAG_W+LSB_W)'(a_coef_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_en) begin
            b_prod_reg    <= b_prod_full[PROD_W-1:0];
            b_divisor_reg <= a_divisor_reg;
            b_side_reg    <= a_side_reg;
        end
    end

    // ---------------- divider stages ----------------
    logic [QUO_W-1:0] div_quotient;
    side_t            div_side;

    pmrs_div_pipe u_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (b_valid_reg),
        .in_ready     (div_in_ready),
        .in_dividend  (b_prod_reg),
        .in_divisor   (b_divisor_reg),
        .in_side      (b_side_reg),
        .out_valid    (div_out_valid),
        .out_ready    (o_en),
        .out_quotient (div_quotient),
        .out_side     (div_side)
    );

    // ---------------- output stage: restore sign ----------------
    logic [VAL_W-1:0] o_mag;
    logic [VAL_W-1:0] o_value_next, o_value_reg;
    logic             o_err_reg;

    assign o_mag        = {1'b0, div_quotient};
    assign o_value_next = div_side.neg ? (VAL_W'(0) - o_mag) : o_mag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (o_en) begin
            o_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (o_en) begin
            o_value_reg <= o_value_next;
            o_err_reg   <= div_side.err;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {{(TDATA_W - VAL_W){1'b0}}, o_value_reg};
    assign m_axis_tuser  = o_err_reg;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tdata[VAL_W-1:0] == '0)
        else $error("flagged result carries a nonzero value");

    a_no_take_after_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_write |=> !s_accept)
        else $error("word taken while setup recomputes");

    a_reset_blocks_input: assert property (@(posedge aclk)
        !aresetn |=> !s_axis_tready)
        else $error("input ready right after reset");
`endif

endmodule

[hw/rtl/pmrs_div_pipe.sv]
// Pipelined restoring divider by a small divisor, four quotient bits per stage.
module pmrs_div_pipe (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pmrs_pkg::PROD_W-1:0]   in_dividend,
    input  logic [pmrs_pkg::DIVR_W-1:0]   in_divisor,
    input  pmrs_pkg::side_t               in_side,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pmrs_pkg::QUO_W-1:0]    out_quotient,
    output pmrs_pkg::side_t               out_side
);
    import pmrs_pkg::*;

    logic [DIV_STAGES-1:0] valid_reg;
    logic [DIV_STAGES-1:0] en;
    logic [DIVR_W-1:0]     rem_reg     [DIV_STAGES];
    logic [QUO_W-1:0]      work_reg    [DIV_STAGES];
    logic [DIVR_W-1:0]     divisor_reg [DIV_STAGES];
    side_t                 side_reg    [DIV_STAGES];

    // Stage moves when empty or when the next one moves
    always_comb begin
        en[DIV_STAGES-1] = !valid_reg[DIV_STAGES-1] || out_ready;
        for (int k = DIV_STAGES - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic              src_valid;
        logic [DIVR_W-1:0] src_rem;
        logic [QUO_W-1:0]  src_work;
        logic [DIVR_W-1:0] src_divisor;
        side_t             src_side;
        logic [DIVR_W-1:0] rem_next;
        logic [QUO_W-1:0]  work_next;

        if (k == 0) begin : g_first
            // upper dividend bits are always below the divisor
            assign src_valid   = in_valid;
            assign src_rem     = {{(DIVR_W - (PROD_W - QUO_W)){1'b0}},
                                  in_dividend[PROD_W-1:QUO_W]};
            assign src_work    = in_dividend[QUO_W-1:0];
            assign src_divisor = in_divisor;
            assign src_side    = in_side;
        end else begin : g_next
            assign src_valid   = valid_reg[k-1];
            assign src_rem     = rem_reg[k-1];
            assign src_work    = work_reg[k-1];
            assign src_divisor = divisor_reg[k-1];
            assign src_side    = side_reg[k-1];
        end

        always_comb begin
            logic [DIVR_W:0]   sh;
            logic [DIVR_W-1:0] rem;
            logic [QUO_W-1:0]  work;
            rem  = src_rem;
            work = src_work;
            for (int i = 0; i < DIV_STEP; i++) begin
                sh = {rem, work[QUO_W-1]};
                if (sh >= {1'b0, src_divisor}) begin
                    sh   = sh - {1'b0, src_divisor};
                    work = {work[QUO_W-2:0], 1'b1};
                end else begin
                    work = {work[QUO_W-2:0], 1'b0};
                end
                rem = sh[DIVR_W-1:0];
            end
            rem_next  = rem;
            work_next = work;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en[k]) begin
                valid_reg[k] <= src_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                rem_reg[k]     <= rem_next;
                work_reg[k]    <= work_next;
                divisor_reg[k] <= src_divisor;
                side_reg[k]    <= src_side;
            end
        end
    end

    assign out_valid    = valid_reg[DIV_STAGES-1];
    assign out_quotient = work_reg[DIV_STAGES-1];
    assign out_side     = side_reg[DIV_STAGES-1];

endmodule

[hw/rtl/pmrs_derive.sv]
// Setup sequencer: derives current LSB, calibration word and error from the registers.
module pmrs_derive (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [15:0]           shunt,
    input  logic [15:0]           corr,
    output pmrs_pkg::scale_t      scale
);
    import pmrs_pkg::*;

    der_state_t        state_reg, state_next;
    logic [31:0]       rem_reg, rem_next;
    logic [SER_W-1:0]  work_reg, work_next;
    logic [31:0]       divisor_reg, divisor_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [9:0]        decade_reg, decade_next;
    logic [16:0]       ma_reg, ma_next;
    logic [LSB_W-1:0]  lsb_reg, lsb_next;
    logic [15:0]       cal_reg, cal_next;
    logic              err_reg, err_next;

    // one restoring step per cycle
    logic [32:0]       sh;
    logic              ge;
    logic [31:0]       rem_step;
    logic [SER_W-1:0]  work_step;
    logic [16:0]       q_val;
    logic [9:0]        decade_sel;
    logic [16:0]       ma_prod;
    logic [36:0]       na_prod;
    logic [37:0]       den_prod;
    logic [41:0]       den_k_prod;
    logic [32:0]       num_prod;

    assign sh        = {rem_reg, work_reg[SER_W-1]};
    assign ge        = sh >= {1'b0, divisor_reg};
    assign rem_step  = ge ? 32'(sh - {1'b0, divisor_reg}) : sh[31:0];
    assign work_step = {work_reg[SER_W-2:0], ge};

    assign q_val      = work_reg[16:0];
    assign decade_sel = (q_val >= 17'(DEC_THOUSAND)) ? DEC_THOUSAND :
                        (q_val >= 17'(DEC_HUNDRED))  ? DEC_HUNDRED  : DEC_TEN;
    assign ma_prod    = 17'(work_reg[6:0]) * 17'(decade_reg);
    assign na_prod    = 37'(ma_reg) * 37'(NA_PER_MA);
    assign den_prod   = 38'(lsb_reg) * 38'(shunt);
    assign den_k_prod = 42'(divisor_reg) * 42'(DEN_SCALE);
    assign num_prod   = 33'(corr) * 33'(CAL_NUM_K);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            DER_IDLE:    state_next = DER_IDLE;
            DER_START:   state_next = (shunt == 16'd0) ? DER_IDLE : DER_DIV_Q;
            DER_DIV_Q:   if (cnt_reg == '0) state_next = DER_ROUND;
            DER_ROUND:   state_next = DER_DIV_K;
            DER_DIV_K:   if (cnt_reg == '0) state_next = DER_MA;
            DER_MA:      state_next = DER_LSB;
            DER_LSB:     state_next = (ma_reg == '0) ? DER_IDLE : DER_DEN;
            DER_DEN:     state_next = DER_DEN_K;
            DER_DEN_K:   state_next = DER_DIV_CAL;
            DER_DIV_CAL: if (cnt_reg == '0) state_next = DER_IDLE;
            default:     state_next = DER_START;
        endcase
        if (start) begin
            state_next = DER_START;
        end
    end

    // datapath
    always_comb begin
        rem_next     = rem_reg;
        work_next    = work_reg;
        divisor_next = divisor_reg;
        cnt_next     = cnt_reg;
        decade_next  = decade_reg;
        ma_next      = ma_reg;
        lsb_next     = lsb_reg;
        cal_next     = cal_reg;
        err_next     = err_reg;
        case (state_reg)
            DER_START: begin
                // 81920 / shunt; a zero shunt means no full-scale current
                err_next     = (shunt == 16'd0);
                rem_next     = '0;
                work_next    = SER_W'(FULL_SCALE_NUM);
                divisor_next = 32'(shunt);
                cnt_next     = SER_LAST;
            end
            DER_DIV_Q, DER_DIV_K: begin
                rem_next  = rem_step;
                work_next = work_step;
                cnt_next  = cnt_reg - 1'b1;
            end
            DER_ROUND: begin
                // q / decade, later times decade: round down to leading decade
                decade_next  = decade_sel;
                rem_next     = '0;
                work_next    = SER_W'(q_val);
                divisor_next = 32'(decade_sel);
                cnt_next     = SER_LAST;
            end
            DER_MA: begin
                ma_next = ma_prod;
            end
            DER_LSB: begin
                err_next = (ma_reg == '0);
                lsb_next = na_prod[LSB_SHIFT +: LSB_W];
            end
            DER_DEN: begin
                divisor_next = den_prod[31:0];
            end
            DER_DEN_K: begin
                divisor_next = den_k_prod[31:0];
                rem_next     = '0;
                work_next    = {num_prod, {CAL_NUM_SHIFT{1'b0}}};
                cnt_next     = SER_LAST;
            end
            DER_DIV_CAL: begin
                rem_next  = rem_step;
                work_next = work_step;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    cal_next = (work_step[SER_W-1:16] != '0) ? 16'hFFFF : work_step[15:0];
                end
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DER_START;
            err_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        work_reg    <= work_next;
        divisor_reg <= divisor_next;
        cnt_reg     <= cnt_next;
        decade_reg  <= decade_next;
        ma_reg      <= ma_next;
        lsb_reg     <= lsb_next;
        cal_reg     <= cal_next;
    end

    assign scale.ready = (state_reg == DER_IDLE);
    assign scale.err   = err_reg;
    assign scale.lsb   = lsb_reg;
    assign scale.cal   = cal_reg;

`ifndef SYNTHESIS
    a_start_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> state_reg == DER_START)
        else $error("setup did not restart after a register write");

    a_lsb_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == DER_IDLE && !err_reg) |-> lsb_reg != '0)
        else $error("valid setup with zero current LSB");
`endif

endmodule

[verif/power_monitor_reading_scaler_checker.sv]
// Checker for the power monitor reading scaler: predicts each result word and compares it.
`timescale 1ns / 100ps

module power_monitor_reading_scaler_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,
    input  logic [1:0]                     s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [pmrs_pkg::TDATA_W-1:0]   m_axis_tdata,
    input  logic [0:0]                     m_axis_tuser,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [0:0]                     cfg_index,
    input  logic [15:0]                    cfg_wdata,
    output int                             fail_count,
    output int                             pending
);
    import pmrs_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             err;
    } reading_t;

    reading_t    expected_readings[$];
    logic [15:0] shunt_mohm;
    logic [15:0] corr_milli;
    int          results_seen;

    // Scaled value for one raw word under the given shunt and correction
    function automatic reading_t scale_reading(input op_t op, input logic [15:0] raw,
                                               input logic [15:0] shunt,
                                               input logic [15:0] corr);
        longint unsigned quot;
        longint unsigned full_ma;
        longint unsigned lsb_na;
        longint unsigned mag;
        longint unsigned prod;
        longint unsigned den;
        longint unsigned word;
        longint unsigned shunt_l;
        longint unsigned corr_l;
        reading_t        res;

        res.value = '0;
        res.err   = 1'b0;
        shunt_l   = 64'(shunt);
        corr_l    = 64'(corr);
        mag       = 64'(raw);
        full_ma   = 0;
        // full-scale mA, rounded down to its leading decade
        if (shunt_l != 0) begin
            quot = 64'd81920 / shunt_l;
            if (quot >= 1000)
                full_ma = quot / 1000 * 1000;
            else if (quot >= 100)
                full_ma = quot / 100 * 100;
            else
                full_ma = quot / 10 * 10;
        end
        lsb_na = full_ma * 1000000 / 32768;

        if (op == OP_BUS_VOLTAGE) begin
            res.value = VAL_W'(mag * 125 / 100);
        end else if (full_ma == 0) begin
            res.err = 1'b1;
        end else begin
            case (op)
                OP_CURRENT: begin
                    if (raw[15])
                        mag = 64'd65536 - mag;
                    prod = mag * lsb_na / 1000;
                    res.value = raw[15] ? VAL_W'(64'd0 - prod) : VAL_W'(prod);
                end
                OP_POWER: begin
                    res.value = VAL_W'(mag * lsb_na / 40);
                end
                default: begin
                    den  = lsb_na * shunt_l * 1000;
                    word = 64'd5120000000 * corr_l / den;
                    res.value = (word > 64'hFFFF) ? VAL_W'(16'hFFFF) : VAL_W'(word);
                end
            endcase
        end
        return res;
    endfunction

    initial begin
        fail_count   = 0;
        pending      = 0;
        results_seen = 0;
        shunt_mohm   = 16'd10;
        corr_milli   = 16'd1000;
    end

    always @(posedge aclk) begin
        reading_t want;
        reading_t got;

        if (!aresetn) begin
            shunt_mohm = 16'd10;
            corr_milli = 16'd1000;
            expected_readings.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_SHUNT: shunt_mohm = cfg_wdata;
                    CFG_CORR:  corr_milli = cfg_wdata;
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
                expected_readings.push_back(scale_reading(op_t'(s_axis_tuser), s_axis_tdata,
                                                          shunt_mohm, corr_milli));

            if (m_axis_tvalid && m_axis_tready) begin
                got.value = m_axis_tdata[VAL_W-1:0];
                got.err   = m_axis_tuser[0];
                if (expected_readings.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result word %0d with nothing expected: value %0h error %0b",
                                 results_seen, got.value, got.err);
                end else begin
                    want = expected_readings.pop_front();
                    if (got.value !== want.value || got.err !== want.err) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result word %0d: value exp %0d got %0d, error exp %0b got %0b",
                                     results_seen, $signed(want.value), $signed(got.value),
                                     want.err, got.err);
                    end
                end
                results_seen++;
            end
        end
        pending <= expected_readings.size();
    end

endmodule

[verif/power_monitor_reading_scaler_tb.sv]
// Testbench top for the power monitor reading scaler: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module power_monitor_reading_scaler_tb;
    import pmrs_pkg::*;

    localparam int RESET_CYCLES  = 9;
    localparam int WORD_TARGET   = 500;
    localparam int HOLD_CYCLES   = 150;   // long receiver hold-off, fills the pipeline
    localparam int STALL_LIMIT   = 2000;  // idle cycles before the watchdog trips
    localparam int DRAIN_CYCLES  = 20;    // margin past the pipeline latency

    logic                 aclk;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata;   // [15:0] raw_word
    logic [1:0]           s_axis_tuser;   // [1:0] operation
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [TDATA_W-1:0]   m_axis_tdata;   // [32:0] scaled_value, rest zero
    logic [0:0]           m_axis_tuser;   // [0] scale_error
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [0:0]           cfg_index;
    logic [15:0]          cfg_wdata;

    int   fail_count;
    int   pending;
    int   words_sent;
    int   idle_cycles;
    logic hold_req;
    logic hold_done;

    op_t         all_ops[4]     = '{OP_BUS_VOLTAGE, OP_CURRENT, OP_POWER, OP_CALIBRATION};
    logic [15:0] corner_raws[4] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};

    power_monitor_reading_scaler i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    power_monitor_reading_scaler_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // 10 ns clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Watchdog: any handshake on any channel counts as progress.
    // Reset plus the setup pass, the long hold-off and the longest
    // gaps all stay well under the limit.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Offer one word at a falling edge, hold it until taken, then maybe pause.
    // Mostly back to back, some short gaps, a few long ones.
    task automatic send_reading(input op_t op, input logic [15:0] raw);
        int r;
        int gap;
        s_axis_tuser  = op;
        s_axis_tdata  = raw;
        s_axis_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        words_sent++;
        @(negedge aclk);
        r = $urandom_range(0, 99);
        if (r < 60)
            gap = 0;
        else if (r < 95)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Stop offering and wait for every expected result word to come back.
    // Each word gives exactly one result, so an empty queue means the pipe is empty.
    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge aclk);
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [15:0] value);
        cfg_index = idx;
        cfg_wdata = value;
        cfg_valid = 1'b1;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_scaling(input logic [15:0] shunt, input logic [15:0] corr);
        wait_drained();
        write_register(CFG_SHUNT, shunt);
        write_register(CFG_CORR, corr);
    endtask

    // Receiver: ready in runs, short stalls, rare long stalls, and one long
    // hold-off on request so the input side backs up.
    initial begin
        int r;
        int n;
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        @(negedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                m_axis_tready = 1'b0;
                hold_done     = 1'b1;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    m_axis_tready = 1'b1;
                    n = $urandom_range(1, 30);
                end else if (r < 95) begin
                    m_axis_tready = 1'b0;
                    n = $urandom_range(1, 3);
                end else begin
                    m_axis_tready = 1'b0;
                    n = $urandom_range(15, 40);
                end
                repeat (n) @(negedge aclk);
            end
        end
    end

    // Main stimulus
    initial begin
        logic [15:0] shunt_corners[5];
        logic [15:0] corr_corners[5];
        logic [15:0] shunt;
        logic [15:0] corr;
        logic [15:0] raw;
        int          r;
        int          n;

        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_BUS_VOLTAGE;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_SHUNT;
        cfg_wdata     = '0;
        hold_req      = 1'b0;
        words_sent    = 0;
        idle_cycles   = 0;

        // zero shunt, shunt of one, calibration saturation,
        // smallest nonzero full scale with tiny correction, zero full scale
        shunt_corners = '{16'd0, 16'd1, 16'd2, 16'd8192, 16'd65535};
        corr_corners  = '{16'd1000, 16'd0, 16'd65535, 16'd1, 16'd1000};

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings: every operation against sign and range corners
        foreach (all_ops[k])
            foreach (corner_raws[j])
                send_reading(all_ops[k], corner_raws[j]);

        // Corner settings: most negative current and the calibration word
        foreach (shunt_corners[k]) begin
            set_scaling(shunt_corners[k], corr_corners[k]);
            send_reading(OP_CURRENT, 16'h8000);
            send_reading(OP_CALIBRATION, 16'hFFFF);
        end

        // Random phases, each under fresh settings
        while (words_sent < WORD_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                shunt = 16'($urandom_range(2, 8192));
            else if (r < 85)
                shunt = 16'($urandom_range(8193, 65535));
            else if (r < 92)
                shunt = 16'($urandom_range(2, 20));
            else
                shunt = shunt_corners[$urandom_range(0, 4)];
            r = $urandom_range(0, 99);
            if (r < 70)
                corr = 16'($urandom_range(0, 65535));
            else
                corr = corr_corners[$urandom_range(0, 4)];
            set_scaling(shunt, corr);

            // first random phase carries the long receiver hold-off
            if (!hold_req) begin
                hold_req = 1'b1;
                n = 60;
            end else begin
                n = $urandom_range(20, 60);
            end

            repeat (n) begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    raw = 16'($urandom_range(0, 65535));
                else
                    raw = corner_raws[$urandom_range(0, 3)];
                send_reading(all_ops[$urandom_range(0, 3)], raw);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
